// ===== sv/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg: shared types and constants of the polynomial term parser
// Field widths, character codes, and the result record that moves from the
// term controller through the output stage to the stream port.
// ----------------------------------------------------------------------------
package ptp_pkg;

  // Field widths
  localparam int unsigned COEF_BITS = 32;
  localparam int unsigned DEG_BITS  = 16;
  localparam int unsigned CH_BITS   = 8;

  // Output tdata: coef then deg, padded to whole bytes
  localparam int unsigned M_PAYLOAD_BITS = COEF_BITS + DEG_BITS;
  localparam int unsigned M_TDATA_BITS   = ((M_PAYLOAD_BITS + 7) / 8) * 8;

  // Character codes
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_X     = 8'h78;
  localparam logic [CH_BITS-1:0] CH_CARET = 8'h5E;

  // One result transaction
  typedef struct packed {
    logic [COEF_BITS-1:0] coef;
    logic [DEG_BITS-1:0]  deg;
    logic                 term_valid;
    logic                 last_term;
  } ptp_result_t;

endpackage

// ===== sv/ptp_term_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptp_term_ctrl: per-term parse state and result formation
// Classifies one character, updates the open term, and forms the term that
// the character closes (or the end marker on the final character).
// ----------------------------------------------------------------------------
module ptp_term_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,   // consume ch_i/last_i this cycle
  input  logic [ptp_pkg::CH_BITS-1:0] ch_i,
  input  logic                        last_i,
  output logic                        emit_o,   // ch_i/last_i produce a result
  output ptp_pkg::ptp_result_t        result_o
);
  import ptp_pkg::*;

  localparam logic [COEF_BITS-1:0] COEF_CAP     = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_POS_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_ONE     = {{(COEF_BITS-1){1'b0}}, 1'b1};
  localparam logic [DEG_BITS-1:0]  DEG_ONE      = {{(DEG_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic                 started;
    logic                 negative;
    logic [COEF_BITS-1:0] coef_mag;
    logic                 coef_stopped;
    logic                 prefix_nonempty;
    logic                 x_seen;
    logic                 expect_caret;
    logic                 exp_active;
    logic [DEG_BITS-1:0]  exp_value;
    logic                 exp_stopped;
  } term_state_t;

  // Decimal accumulate, saturating at COEF_CAP
  function automatic logic [COEF_BITS-1:0] acc_coef(input logic [COEF_BITS-1:0] v,
                                                    input logic [3:0] d);
    logic [COEF_BITS+3:0] ext;
    logic [COEF_BITS+3:0] sum;
    ext = {4'b0000, v};
    sum = (ext << 3) + (ext << 1) + {{COEF_BITS{1'b0}}, d};
    if (sum > {4'b0000, COEF_CAP}) begin
      return COEF_CAP;
    end
    return sum[COEF_BITS-1:0];
  endfunction

  // Decimal accumulate, saturating at the largest degree
  function automatic logic [DEG_BITS-1:0] acc_deg(input logic [DEG_BITS-1:0] v,
                                                  input logic [3:0] d);
    logic [DEG_BITS+3:0] ext;
    logic [DEG_BITS+3:0] sum;
    ext = {4'b0000, v};
    sum = (ext << 3) + (ext << 1) + {{DEG_BITS{1'b0}}, d};
    if (sum[DEG_BITS+3:DEG_BITS] != 4'b0000) begin
      return {DEG_BITS{1'b1}};
    end
    return sum[DEG_BITS-1:0];
  endfunction

  // Term record from a state
  function automatic ptp_result_t put_term(input term_state_t s);
    ptp_result_t          r;
    logic [COEF_BITS-1:0] mag;
    mag = (s.x_seen && !s.prefix_nonempty) ? COEF_ONE : s.coef_mag;
    if (s.negative) begin
      r.coef = COEF_BITS'(-mag);
    end else begin
      r.coef = mag[COEF_BITS-1] ? COEF_POS_MAX : mag;
    end
    r.deg        = s.x_seen ? s.exp_value : '0;
    r.term_valid = 1'b1;
    r.last_term  = 1'b0;
    return r;
  endfunction

  term_state_t state_q, state_d, state_mid;

  logic       is_ws, is_sign, is_minus, is_digit, is_x, is_caret;
  logic [3:0] dval;

  // Character classes
  always_comb begin
    is_ws    = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
    is_minus = (ch_i == CH_MINUS);
    is_sign  = (ch_i == CH_PLUS) || is_minus;
    is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_x     = (ch_i == CH_X);
    is_caret = (ch_i == CH_CARET);
    dval     = is_digit ? ch_i[3:0] : 4'd0;
  end

  // Next term state and result
  always_comb begin
    logic sign_emit;
    state_mid = state_q;
    sign_emit = 1'b0;
    result_o  = '0;

    priority if (is_ws) begin
      // whitespace leaves everything as is
    end else if (is_sign) begin
      sign_emit = state_q.started;
      result_o  = put_term(state_q);
      state_mid = '0;
      if (is_minus) begin
        state_mid.started  = 1'b1;
        state_mid.negative = 1'b1;
      end
    end else begin
      state_mid.started = 1'b1;
      priority if (!state_q.x_seen) begin
        if (is_x) begin
          state_mid.x_seen       = 1'b1;
          state_mid.expect_caret = 1'b1;
          state_mid.exp_value    = DEG_ONE;
          state_mid.coef_stopped = 1'b1;
        end else begin
          state_mid.prefix_nonempty = 1'b1;
          if (is_digit && !state_q.coef_stopped) begin
            state_mid.coef_mag = acc_coef(state_q.coef_mag, dval);
          end else begin
            state_mid.coef_stopped = 1'b1;
          end
        end
      end else if (state_q.expect_caret) begin
        state_mid.expect_caret = 1'b0;
        if (is_caret) begin
          state_mid.exp_active = 1'b1;
          state_mid.exp_value  = '0;
        end
      end else if (state_q.exp_active && !state_q.exp_stopped) begin
        if (is_digit) begin
          state_mid.exp_value = acc_deg(state_q.exp_value, dval);
        end else begin
          state_mid.exp_stopped = 1'b1;
        end
      end else begin
        // characters after the degree are ignored
      end
    end

    state_d = state_mid;
    emit_o  = sign_emit;
    // Final character closes the polynomial
    if (last_i) begin
      if (!sign_emit) begin
        result_o = state_mid.started ? put_term(state_mid) : '0;
      end
      emit_o             = 1'b1;
      result_o.last_term = 1'b1;
      state_d            = '0;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> state_q == '0)
    else $error("term state not cleared after final character");
  a_coef_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.coef_mag <= COEF_CAP)
    else $error("coefficient magnitude above saturation cap");
  a_deg_only_after_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.x_seen |-> (state_q.exp_value == '0) && !state_q.expect_caret
                        && !state_q.exp_active)
    else $error("degree state active without x");
`endif

endmodule

// ===== sv/ptp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ptp_out_stage: result register of the parser
// Holds one result transaction for the master side; it reloads in the same
// cycle in which the held transaction is taken.
// ----------------------------------------------------------------------------
module ptp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ptp_pkg::ptp_result_t result_i,
  output logic                 can_load_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ptp_pkg::ptp_result_t result_o
);
  import ptp_pkg::*;

  logic        valid_q, valid_d;
  ptp_result_t data_q;

  assign can_load_o = !valid_q || ready_i;

  // Valid flag: set on load, cleared when taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || ready_i)
    else $error("result register overwritten while held");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("held result changed under stall");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not marked valid");
`endif

endmodule

// ===== sv/polynomial_term_parser_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_term_parser_core: streaming polynomial term parser
// Turns a character stream into (coefficient, degree) term transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one ASCII character per transaction on s_axis_tdata,
//   with s_axis_tlast on the final character of a polynomial. Master side
//   gives one transaction per completed term: tdata holds coef (signed) and
//   deg, tuser is term_valid, tlast marks the final result of a polynomial.
//   A polynomial whose final character closes no term ends with a marker
//   (tuser low, tdata zero, tlast high).
// Timing:
//   One character per cycle while the master side takes results. A character
//   accepted into the input register is parsed there, and its result is
//   loaded into the result register, from which the master side takes it.
//   The path runs through the input register and the result register, with
//   the whole term update between them.
// Reset and stall:
//   Reset empties both registers and clears the open term. While the master
//   side stalls, the result register holds; a character that closes a term
//   waits in the input register, and characters that produce nothing still
//   flow through.
// ----------------------------------------------------------------------------
module polynomial_term_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ptp_pkg::CH_BITS-1:0]      s_axis_tdata,  // [7:0] ch
  input  logic                             s_axis_tlast,  // last
  // master side
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ptp_pkg::M_TDATA_BITS-1:0] m_axis_tdata,  // coef, deg, zero pad
  output logic                             m_axis_tuser,  // term_valid
  output logic                             m_axis_tlast   // last_term
);
  import ptp_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic [CH_BITS-1:0] in_ch_q;
  logic               in_last_q;

  logic        step, emit, can_load;
  ptp_result_t term_res, out_res;

  // Input stage advances unless its result finds the output register full
  assign step          = in_valid_q && (!emit || can_load);
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Term parse
  ptp_term_ctrl u_term_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .ch_i    (in_ch_q),
    .last_i  (in_last_q),
    .emit_o  (emit),
    .result_o(term_res)
  );

  // Result register
  ptp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && emit),
    .result_i  (term_res),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .result_o  (out_res)
  );

  // Master payload packing
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[COEF_BITS-1:0]                  = out_res.coef;
    m_axis_tdata[M_PAYLOAD_BITS-1:COEF_BITS]     = out_res.deg;
  end
  assign m_axis_tuser = out_res.term_valid;
  assign m_axis_tlast = out_res.last_term;

`ifndef SYNTHESIS
  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("end marker without last flag");
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("end marker carries nonzero payload");
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_ch_q) && $stable(in_last_q))
    else $error("blocked character lost from input register");
`endif

endmodule
